[design/lhpi_pkg.sv]
`default_nettype none

package lhpi_pkg;

    localparam int MAX_SIDE_DEF = 32;

    localparam int OP_W     = 1;
    localparam int COORD_W  = 7;
    localparam int PIX_W    = 8;
    localparam int SIZE_W   = 6;
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W = 1;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 8;

    localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
    localparam logic [OP_W-1:0] OP_READ  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

    typedef enum logic [KIND_W-1:0] {
        KIND_ORIG   = 2'd0,
        KIND_HALF_H = 2'd1,
        KIND_HALF_V = 2'd2,
        KIND_DIAG   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        COEF_ONE    = 2'd0,
        COEF_NEG5   = 2'd1,
        COEF_TWENTY = 2'd2,
        COEF_UNITY  = 2'd3
    } coef_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_ISSUE  = 5'b00010,
        ST_LAST   = 5'b00100,
        ST_OUTER  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    // Filter sums stay within -2550..10710, so 15 bits signed suffice.
    typedef logic signed [14:0] acc_t;

    function automatic coef_t coef_of(input logic [2:0] tap);
        coef_t c;
        begin
            case (tap) inside
                3'd0, 3'd5: c = COEF_ONE;
                3'd1, 3'd4: c = COEF_NEG5;
                3'd2, 3'd3: c = COEF_TWENTY;
                default:    c = COEF_ONE;
            endcase
            return c;
        end
    endfunction

    // Shared multiply-accumulate: acc + coef * x, products built from shifts.
    function automatic acc_t mac(input acc_t acc, input logic [PIX_W-1:0] x,
                                 input coef_t c);
        acc_t xe;
        acc_t prod;
        begin
            xe = acc_t'({7'd0, x});
            case (c)
                COEF_ONE:    prod = xe;
                COEF_NEG5:   prod = -((xe <<< 2) + xe);
                COEF_TWENTY: prod = (xe <<< 4) + (xe <<< 2);
                COEF_UNITY:  prod = xe <<< 5;
                default:     prod = xe;
            endcase
            return acc + prod;
        end
    endfunction

    // (sum + 16) >> 5 clipped to one byte.
    function automatic logic [PIX_W-1:0] round_clip(input acc_t s);
        logic signed [15:0] t;
        logic [10:0] q;
        begin
            t = 16'(s) + 16'sd16;
            q = t[15:5];
            if (t < 0) begin
                return '0;
            end else if (q > 11'd255) begin
                return 8'd255;
            end else begin
                return q[PIX_W-1:0];
            end
        end
    endfunction

endpackage

`default_nettype wire

[design/luma_half_pel_interpolator_unit.sv]
// Luma half-pel interpolator.
// Input stream (s_axis_*): one word per command. A write stores one original
// pixel and leaves the block idle. A read names a doubled-grid position and
// yields one word on the output stream (m_axis_*): the sample and its kind.
// Configuration channel (cfg_*): index 0 frame width, 1 frame height; always
// ready, write only while no read is in flight.
// A read runs a fetch in ST_ISSUE for each tap, one tap for an original pixel
// and six for a half-pel, then passes ST_LAST; a diagonal read does this for
// six rows of six taps, with a vertical filter step in ST_OUTER after each
// row, before ST_FINISH loads the output register. Throughput: writes every
// cycle while idle; after a read the next command is accepted at the
// earliest in the cycle its result is offered.
// All taps go through the single read port of the pixel RAM, one fetch per
// cycle, and one shared multiply-accumulate unit does every filter step.
// The block takes no new command until a read has finished. A finished result
// sits in the output register; a new command is accepted while it waits, but
// a second result waits in the finishing step until the receiver takes the
// first. Reset clears control state and sets both sizes to 32; the pixel RAM
// is not cleared and must be written before it is read.

`default_nettype none

module luma_half_pel_interpolator_unit
    import lhpi_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // operation, row_index, col_index, pixel_value, zero pad
    input  wire logic [S_DATA_W-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // sample_value
    output logic      [M_DATA_W-1:0]  m_axis_tdata,
    // sample_kind
    output logic      [KIND_W-1:0]    m_axis_tuser,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SIZE_W-1:0]    cfg_data
);

    localparam int ADDR_W = $clog2(MAX_SIDE * MAX_SIDE);

    logic [OP_W-1:0]    in_op;
    logic [COORD_W-1:0] in_row;
    logic [COORD_W-1:0] in_col;
    logic [PIX_W-1:0]   in_pix;

    assign in_op  = s_axis_tdata[0];
    assign in_row = s_axis_tdata[7:1];
    assign in_col = s_axis_tdata[14:8];
    assign in_pix = s_axis_tdata[22:15];

    state_t          state_reg, state_next;
    kind_t           kind_reg, kind_next;
    logic [5:0]      base_r_reg, base_r_next;
    logic [5:0]      base_c_reg, base_c_next;
    logic [2:0]      j_reg, j_next;
    logic [2:0]      k_reg, k_next;
    logic            tap_vld_reg, tap_vld_next;
    logic            tap_first_reg, tap_first_next;
    coef_t           tap_coef_reg, tap_coef_next;
    acc_t            h_acc_reg, h_acc_next;
    acc_t            v_acc_reg, v_acc_next;
    logic [SIZE_W-1:0] width_reg, width_next;
    logic [SIZE_W-1:0] height_reg, height_next;
    logic            m_valid_reg, m_valid_next;
    logic [PIX_W-1:0] m_sample_reg, m_sample_next;
    kind_t           m_kind_reg, m_kind_next;

    logic [SIZE_W-1:0] eff_w, eff_h;
    logic [COORD_W-1:0] lim_r, lim_c, rowc, colc;
    logic            in_accept;
    logic            cfg_accept;

    logic [2:0]        inner_last;
    logic signed [8:0] off_k, off_j, row_off, col_off, tap_r, tap_c;
    logic [5:0]        wr_r, wr_c, rd_r, rd_c;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [PIX_W-1:0]  ram_rdata;

    logic [PIX_W-1:0] h_clip;
    logic [PIX_W-1:0] unit_x;
    coef_t            unit_c;
    acc_t             unit_acc, unit_out;

    function automatic logic [5:0] clamp_coord(input logic signed [8:0] v,
                                               input logic [SIZE_W-1:0] n);
        logic signed [8:0] top;
        begin
            top = $signed({3'd0, n}) - 9'sd1;
            if (v < 0) begin
                return '0;
            end else if (v > top) begin
                return top[5:0];
            end else begin
                return v[5:0];
            end
        end
    endfunction

    function automatic logic [SIZE_W-1:0] eff_side(input logic [SIZE_W-1:0] v);
        begin
            if (v == '0) begin
                return 6'd1;
            end else if ({2'd0, v} > 8'(MAX_SIDE)) begin
                return 6'(MAX_SIDE);
            end else begin
                return v;
            end
        end
    endfunction

    assign eff_w = eff_side(width_reg);
    assign eff_h = eff_side(height_reg);
    assign lim_r = {eff_h, 1'b0};
    assign lim_c = {eff_w, 1'b0};
    assign rowc  = (in_row > lim_r) ? lim_r : in_row;
    assign colc  = (in_col > lim_c) ? lim_c : in_col;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign cfg_accept    = cfg_valid && cfg_ready;

    // Write path: clamp to the last original row and column.
    assign wr_r      = clamp_coord($signed({2'd0, in_row}), eff_h);
    assign wr_c      = clamp_coord($signed({2'd0, in_col}), eff_w);
    assign ram_we    = in_accept && (in_op == OP_WRITE);
    assign ram_waddr = ADDR_W'(wr_r) * ADDR_W'(MAX_SIDE) + ADDR_W'(wr_c);

    // Tap coordinates of the fetch issued this cycle.
    assign inner_last = (kind_reg == KIND_ORIG) ? 3'd0 : 3'd5;
    assign off_k      = $signed({6'd0, k_reg}) - 9'sd3;
    assign off_j      = $signed({6'd0, j_reg}) - 9'sd3;

    always_comb begin
        case (kind_reg)
            KIND_ORIG: begin
                row_off = '0;
                col_off = '0;
            end
            KIND_HALF_H: begin
                row_off = '0;
                col_off = off_k;
            end
            KIND_HALF_V: begin
                row_off = off_k;
                col_off = '0;
            end
            KIND_DIAG: begin
                row_off = off_j;
                col_off = off_k;
            end
            default: begin
                row_off = '0;
                col_off = '0;
            end
        endcase
    end

    assign tap_r     = $signed({3'd0, base_r_reg}) + row_off;
    assign tap_c     = $signed({3'd0, base_c_reg}) + col_off;
    assign rd_r      = clamp_coord(tap_r, eff_h);
    assign rd_c      = clamp_coord(tap_c, eff_w);
    assign ram_raddr = ADDR_W'(rd_r) * ADDR_W'(MAX_SIDE) + ADDR_W'(rd_c);

    lhpi_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (MAX_SIDE * MAX_SIDE)
    ) u_pixel_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_pix),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared MAC: taps during fetch, vertical pass over row results in ST_OUTER.
    assign h_clip = round_clip(h_acc_reg);

    always_comb begin
        if (state_reg == ST_OUTER) begin
            unit_x   = h_clip;
            unit_c   = coef_of(j_reg);
            unit_acc = (j_reg == 3'd0) ? acc_t'(0) : v_acc_reg;
        end else begin
            unit_x   = ram_rdata;
            unit_c   = tap_coef_reg;
            unit_acc = tap_first_reg ? acc_t'(0) : h_acc_reg;
        end
    end

    assign unit_out = mac(unit_acc, unit_x, unit_c);

    always_comb begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        base_r_next    = base_r_reg;
        base_c_next    = base_c_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        tap_vld_next   = 1'b0;
        tap_first_next = tap_first_reg;
        tap_coef_next  = tap_coef_reg;
        h_acc_next     = h_acc_reg;
        v_acc_next     = v_acc_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        m_sample_next  = m_sample_reg;
        m_kind_next    = m_kind_reg;

        if (cfg_accept) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  width_next  = cfg_data;
                REG_FRAME_HEIGHT: height_next = cfg_data;
                default: ;
            endcase
        end

        if (tap_vld_reg) begin
            h_acc_next = unit_out;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_accept && (in_op == OP_READ)) begin
                    base_r_next = rowc[6:1];
                    base_c_next = colc[6:1];
                    j_next      = '0;
                    k_next      = '0;
                    case ({rowc[0], colc[0]})
                        2'b11:   kind_next = KIND_ORIG;
                        2'b10:   kind_next = KIND_HALF_H;
                        2'b01:   kind_next = KIND_HALF_V;
                        default: kind_next = KIND_DIAG;
                    endcase
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                tap_vld_next   = 1'b1;
                tap_first_next = (k_reg == 3'd0);
                // An original pixel passes through with weight 32.
                tap_coef_next  = (kind_reg == KIND_ORIG) ? COEF_UNITY : coef_of(k_reg);
                if (k_reg == inner_last) begin
                    state_next = ST_LAST;
                end else begin
                    k_next = k_reg + 3'd1;
                end
            end
            ST_LAST: begin
                state_next = (kind_reg == KIND_DIAG) ? ST_OUTER : ST_FINISH;
            end
            ST_OUTER: begin
                v_acc_next = unit_out;
                if (j_reg == 3'd5) begin
                    state_next = ST_FINISH;
                end else begin
                    j_next     = j_reg + 3'd1;
                    k_next     = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_FINISH: begin
                // Hold until the output register is free.
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next  = 1'b1;
                    m_sample_next = (kind_reg == KIND_DIAG) ? round_clip(v_acc_reg)
                                                            : h_clip;
                    m_kind_next   = kind_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            tap_vld_reg <= 1'b0;
            width_reg   <= SIZE_RESET;
            height_reg  <= SIZE_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            tap_vld_reg <= tap_vld_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg      <= kind_next;
        base_r_reg    <= base_r_next;
        base_c_reg    <= base_c_next;
        j_reg         <= j_next;
        k_reg         <= k_next;
        tap_first_reg <= tap_first_next;
        tap_coef_reg  <= tap_coef_next;
        h_acc_reg     <= h_acc_next;
        v_acc_reg     <= v_acc_next;
        m_sample_reg  <= m_sample_next;
        m_kind_reg    <= m_kind_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_sample_reg;
    assign m_axis_tuser  = m_kind_reg;

    a_read_goes_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && (in_op == OP_READ)) |=> !s_axis_tready)
        else $error("read accepted but block still ready");

    a_write_single_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && (in_op == OP_WRITE)) |=> s_axis_tready)
        else $error("write did not return to idle");

    a_tap_data_in_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        tap_vld_reg |-> (state_reg == ST_ISSUE || state_reg == ST_LAST))
        else $error("tap data arrived outside a fetch run");

    a_outer_only_diag: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUTER) |-> (kind_reg == KIND_DIAG && !tap_vld_reg))
        else $error("vertical pass entered for a non-diagonal read");

endmodule

`default_nettype wire

[design/lhpi_ram.sv]
`default_nettype none

module lhpi_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]        wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
